@@ sv/ufl_pkg.sv @@
// Shared types and constants of the serial byte deframer.
// Command and status structs between controller and datapath, byte codes.
// No dependencies; compiled first.
`default_nettype none

package ufl_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;

  // Special byte values
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;

  // Smallest length byte that opens a frame, and the frame's first position
  localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd2;
  localparam logic [POS_W-1:0]  FRAME_LPOS = 9'd2;

  // Result kind codes
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TEXT  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;        // an input item is accepted this cycle
    logic drain_read;  // read the line store at the drain index
    logic drain_load;  // move the read byte into the output register
  } ufl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or being taken
    logic line_end;    // offered byte ends a non-empty line
    logic drain_last;  // drain index points at the final stored byte
  } ufl_status_t;

  // Bytes that may stand in a text line
  function automatic logic is_line_char(input logic [BYTE_W-1:0] c);
    logic ok;
    ok = ((c >= 8'h30) && (c <= 8'h39)) ||   // 0-9
         ((c >= 8'h41) && (c <= 8'h5A)) ||   // A-Z
         ((c >= 8'h61) && (c <= 8'h7A)) ||   // a-z
         (c == 8'h2C) || (c == 8'h5F) ||     // comma, underscore
         (c == 8'h2D) || (c == 8'h20) ||     // hyphen, space
         (c == 8'h09);                       // tab
    return ok;
  endfunction

endpackage

`default_nettype wire

@@ sv/ufl_if.sv @@
// Valid/ready channel interfaces of the serial byte deframer.
// Input channel carries one received byte, result channel one emitted byte.
// No dependencies.
`default_nettype none

interface ufl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufl_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic [8:0] position;
  logic       last;

  modport source (output valid, output kind, output data, output position, output last,
                  input ready);
  modport sink   (input valid, input kind, input data, input position, input last,
                  output ready);
endinterface

`default_nettype wire

@@ sv/ufl_ctrl.sv @@
// Controller of the serial byte deframer: idle / line drain sequencing.
// Issues commands to ufl_datapath and reads its status.
// Depends on ufl_pkg.
`default_nettype none

module ufl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  ufl_pkg::ufl_status_t status_i,
  output ufl_pkg::ufl_cmd_t    cmd_o
);
  import ufl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    rx_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        rx_ready_o = status_i.out_free;
        cmd_o.take = rx_valid_i && status_i.out_free;
        if (cmd_o.take && status_i.line_end) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.drain_read = 1'b1;
        state_d          = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.drain_load = status_i.out_free;
        if (status_i.out_free) begin
          state_d = status_i.drain_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ufl_datapath.sv @@
// Datapath of the serial byte deframer: frame tracking, line store, output register.
// Driven by ufl_ctrl through ufl_cmd_t, reports ufl_status_t.
// Depends on ufl_pkg.
`default_nettype none

module ufl_datapath #(
  parameter int unsigned LINE_BUFFER = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ufl_pkg::ufl_cmd_t    cmd_i,
  output ufl_pkg::ufl_status_t status_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output logic                 res_kind_o,
  output logic [7:0]           res_data_o,
  output logic [8:0]           res_position_o,
  output logic                 res_last_o
);
  import ufl_pkg::*;

  localparam int unsigned LINE_CAP = LINE_BUFFER - 1;
  localparam int unsigned CW       = $clog2(LINE_BUFFER);
  localparam int unsigned AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  // Control state
  logic             sync_seen_q, sync_seen_d;
  logic             in_frame_q, in_frame_d;
  logic [POS_W-1:0] frame_pos_q, frame_pos_d;
  logic [BYTE_W-1:0] frame_len_q, frame_len_d;
  logic [CW-1:0]    text_count_q, text_count_d;
  logic [CW-1:0]    drain_idx_q, drain_idx_d;
  logic             out_valid_q, out_valid_d;

  // Output payload and line store
  logic              out_kind_q;
  logic [BYTE_W-1:0] out_data_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_last_q;
  logic [BYTE_W-1:0] line_mem_q [LINE_CAP];
  logic [BYTE_W-1:0] rd_data_q;

  logic              is_sync, is_eol, at_len, short_len, frame_last, emit_frame;
  logic              drain_last, mem_we;
  logic [POS_W-1:0]  frame_end;

  // Byte decode
  assign is_sync    = (rx_byte_i == SYNC_BYTE);
  assign is_eol     = (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF);
  assign at_len     = (frame_pos_q == FRAME_LPOS);
  assign short_len  = (rx_byte_i < MIN_LEN);
  assign frame_end  = {1'b0, frame_len_q} + 9'd2;
  assign frame_last = !at_len && ((frame_pos_q + 9'd1) == frame_end);
  assign emit_frame = cmd_i.take && in_frame_q && !(at_len && short_len);
  assign drain_last = ((drain_idx_q + CW'(1)) == text_count_q);

  assign status_o.out_free   = !out_valid_q || res_ready_i;
  assign status_o.line_end   = !in_frame_q && !is_sync && is_eol && (text_count_q != '0);
  assign status_o.drain_last = drain_last;

  // Next state of frame and line tracking
  always_comb begin
    sync_seen_d  = sync_seen_q;
    in_frame_d   = in_frame_q;
    frame_pos_d  = frame_pos_q;
    frame_len_d  = frame_len_q;
    text_count_d = text_count_q;
    drain_idx_d  = drain_idx_q;
    mem_we       = 1'b0;
    if (cmd_i.take) begin
      if (!in_frame_q) begin
        if (is_sync) begin
          if (sync_seen_q) begin
            // second sync byte: open a frame, drop the line
            sync_seen_d  = 1'b0;
            in_frame_d   = 1'b1;
            frame_pos_d  = FRAME_LPOS;
            text_count_d = '0;
          end else begin
            sync_seen_d = 1'b1;
          end
        end else begin
          sync_seen_d = 1'b0;
          if (is_eol) begin
            // line kept until the drain has gone through it
          end else if (is_line_char(rx_byte_i) && (text_count_q < CW'(LINE_CAP))) begin
            mem_we       = 1'b1;
            text_count_d = text_count_q + CW'(1);
          end else begin
            text_count_d = '0;
          end
        end
      end else if (at_len && short_len) begin
        // short length: drop the frame
        frame_len_d = MIN_LEN;
        in_frame_d  = 1'b0;
        frame_pos_d = '0;
      end else begin
        if (at_len) begin
          frame_len_d = rx_byte_i;
        end
        frame_pos_d = frame_pos_q + 9'd1;
        if (frame_last) begin
          in_frame_d  = 1'b0;
          frame_pos_d = '0;
          sync_seen_d = 1'b0;
        end
      end
    end
    if (cmd_i.drain_load) begin
      if (drain_last) begin
        drain_idx_d  = '0;
        text_count_d = '0;
      end else begin
        drain_idx_d = drain_idx_q + CW'(1);
      end
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q && !res_ready_i;
    if (emit_frame || cmd_i.drain_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_seen_q  <= 1'b0;
      in_frame_q   <= 1'b0;
      frame_pos_q  <= '0;
      frame_len_q  <= MIN_LEN;
      text_count_q <= '0;
      drain_idx_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      sync_seen_q  <= sync_seen_d;
      in_frame_q   <= in_frame_d;
      frame_pos_q  <= frame_pos_d;
      frame_len_q  <= frame_len_d;
      text_count_q <= text_count_d;
      drain_idx_q  <= drain_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit_frame) begin
      out_kind_q <= KIND_FRAME;
      out_data_q <= rx_byte_i;
      out_pos_q  <= frame_pos_q;
      out_last_q <= frame_last;
    end else if (cmd_i.drain_load) begin
      out_kind_q <= KIND_TEXT;
      out_data_q <= rd_data_q;
      out_pos_q  <= POS_W'(drain_idx_q);
      out_last_q <= drain_last;
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[text_count_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.drain_read) begin
      rd_data_q <= line_mem_q[drain_idx_q[AW-1:0]];
    end
  end

  assign res_valid_o    = out_valid_q;
  assign res_kind_o     = out_kind_q;
  assign res_data_o     = out_data_q;
  assign res_position_o = out_pos_q;
  assign res_last_o     = out_last_q;

  // Checks
  a_frame_no_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> !sync_seen_q)
    else $error("sync flag set inside a frame");

  a_frame_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (frame_pos_q >= FRAME_LPOS) && (frame_pos_q < frame_end))
    else $error("frame position out of range");

  a_line_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_count_q <= CW'(LINE_CAP))
    else $error("line count beyond capacity");

  a_drain_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_idx_q != '0) |-> (drain_idx_q < text_count_q))
    else $error("drain index beyond stored line");

  a_load_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drain_read |=> !cmd_i.take && !cmd_i.drain_read)
    else $error("line read not followed by a load cycle");

endmodule

`default_nettype wire

@@ sv/uart_frame_and_line_receiver.sv @@
// Frame result: shown in the cycle after its byte is accepted; one byte per cycle while
//   the output register is free.
// Line end (CR/LF): drains the stored line byte by byte (line store read, then output
//   register load once it is free); no byte is accepted during the drain.
// Reset (rst_ni low, asynchronous): clears frame, sync, line count and output valid;
//   the line store keeps its contents and needs no clearing pass.
`default_nettype none

module uart_frame_and_line_receiver #(
  parameter int unsigned LINE_BUFFER = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ufl_rx_if.sink        rx_i,
  ufl_res_if.source     res_o
);
  import ufl_pkg::*;

  ufl_cmd_t    cmd;
  ufl_status_t status;

  // Sequencer
  ufl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tracking, line store and output register
  ufl_datapath #(
    .LINE_BUFFER (LINE_BUFFER)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .rx_byte_i      (rx_i.rx_byte),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .res_kind_o     (res_o.kind),
    .res_data_o     (res_o.data),
    .res_position_o (res_o.position),
    .res_last_o     (res_o.last)
  );

endmodule

`default_nettype wire
